@@ rtl/cbo_pkg.sv @@
// shared widths, codes and stage records for the circle versus box overlap test
package cbo_pkg;

    localparam int COORD_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int SIZE_BITS  = 12;

    // coordinates kept to COORD_BITS, never wider than their field
    localparam int CW = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    // half-pixel centres and distances: room for 2*(pos + margin) + size
    localparam int PW = ((CW > SIZE_BITS) ? CW : SIZE_BITS) + 3;
    // doubled radius, and the corner offsets that never exceed it
    localparam int RW = CW + 1;
    localparam int QW = 2 * RW;
    // signed room for size minus two margins
    localparam int BW = SIZE_BITS + 2;

    localparam logic [1:0] MODE_FULL      = 2'd0;
    localparam logic [1:0] MODE_INSET     = 2'd1;
    localparam logic [1:0] MODE_NOT_SOLID = 2'd2;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    typedef enum logic [1:0] {
        CLS_MISS,
        CLS_HIT,
        CLS_CORNER
    } t_cls;

    typedef struct packed {
        logic                 valid;
        logic                 live;
        logic [SIZE_BITS-1:0] hw;
        logic [SIZE_BITS-1:0] hh;
        logic [PW-1:0]        mx;
        logic [PW-1:0]        my;
        logic [PW-1:0]        cx2;
        logic [PW-1:0]        cy2;
        logic [RW-1:0]        rr;
    } t_geo;

    typedef struct packed {
        logic          valid;
        t_cls          cls;
        logic [RW-1:0] ex;
        logic [RW-1:0] ey;
        logic [RW-1:0] rr;
    } t_dist;

endpackage

@@ rtl/cbo_geometry.sv @@
// box centre and half extents in half-pixel units, chosen by test mode
module cbo_geometry (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [cbo_pkg::CW-1:0]        i_box_x,
    input  logic [cbo_pkg::CW-1:0]        i_box_y,
    input  logic [cbo_pkg::SIZE_BITS-1:0] i_box_width,
    input  logic [cbo_pkg::SIZE_BITS-1:0] i_box_height,
    input  logic [cbo_pkg::SIZE_BITS-1:0] i_inset_left,
    input  logic [cbo_pkg::SIZE_BITS-1:0] i_inset_right,
    input  logic [cbo_pkg::SIZE_BITS-1:0] i_inset_top,
    input  logic [cbo_pkg::SIZE_BITS-1:0] i_inset_bottom,
    input  logic [1:0]                    i_test_mode,
    input  logic [cbo_pkg::CW-1:0]        i_circle_x,
    input  logic [cbo_pkg::CW-1:0]        i_circle_y,
    input  logic [cbo_pkg::CW-1:0]        i_circle_radius,
    output cbo_pkg::t_geo                 o_geo
);
    import cbo_pkg::*;

    logic                 inset;
    logic [BW-1:0]        diff_w;
    logic [BW-1:0]        diff_h;
    logic [SIZE_BITS-1:0] body_w;
    logic [SIZE_BITS-1:0] body_h;
    logic [SIZE_BITS-1:0] off_l;
    logic [SIZE_BITS-1:0] off_t;
    logic [PW-1:0]        left;
    logic [PW-1:0]        top;
    t_geo                 n_geo;
    t_geo                 r_geo;

    always_comb begin
        inset  = (i_test_mode == MODE_INSET);
        diff_w = {2'b00, i_box_width} - {2'b00, i_inset_left} - {2'b00, i_inset_right};
        diff_h = {2'b00, i_box_height} - {2'b00, i_inset_top} - {2'b00, i_inset_bottom};
        // body narrower than zero collapses to a line
        body_w = diff_w[BW-1] ? '0 : diff_w[SIZE_BITS-1:0];
        body_h = diff_h[BW-1] ? '0 : diff_h[SIZE_BITS-1:0];
        off_l  = inset ? i_inset_left : '0;
        off_t  = inset ? i_inset_top : '0;
        left   = PW'(i_box_x) + PW'(off_l);
        top    = PW'(i_box_y) + PW'(off_t);

        n_geo.valid = i_valid;
        n_geo.live  = (i_test_mode == MODE_FULL) || (i_test_mode == MODE_INSET);
        n_geo.hw    = inset ? body_w : i_box_width;
        n_geo.hh    = inset ? body_h : i_box_height;
        n_geo.mx    = {left[PW-2:0], 1'b0} + PW'(n_geo.hw);
        n_geo.my    = {top[PW-2:0], 1'b0} + PW'(n_geo.hh);
        n_geo.cx2   = PW'({i_circle_x, 1'b0});
        n_geo.cy2   = PW'({i_circle_y, 1'b0});
        n_geo.rr    = {i_circle_radius, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geo.valid <= 1'b0;
        end else begin
            r_geo.valid <= n_geo.valid;
        end
        r_geo.live <= n_geo.live;
        r_geo.hw   <= n_geo.hw;
        r_geo.hh   <= n_geo.hh;
        r_geo.mx   <= n_geo.mx;
        r_geo.my   <= n_geo.my;
        r_geo.cx2  <= n_geo.cx2;
        r_geo.cy2  <= n_geo.cy2;
        r_geo.rr   <= n_geo.rr;
    end

    assign o_geo = r_geo;

endmodule

@@ rtl/cbo_distance.sv @@
// centre distances, coarse reach test and corner offsets
module cbo_distance (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cbo_pkg::t_geo  i_geo,
    output cbo_pkg::t_dist o_dist
);
    import cbo_pkg::*;

    logic [PW-1:0] dx;
    logic [PW-1:0] dy;
    logic [PW-1:0] reach_x;
    logic [PW-1:0] reach_y;
    logic [PW-1:0] off_x;
    logic [PW-1:0] off_y;
    logic          far;
    logic          near;
    t_dist         n_dist;
    t_dist         r_dist;

    always_comb begin
        dx      = (i_geo.cx2 >= i_geo.mx) ? i_geo.cx2 - i_geo.mx : i_geo.mx - i_geo.cx2;
        dy      = (i_geo.cy2 >= i_geo.my) ? i_geo.cy2 - i_geo.my : i_geo.my - i_geo.cy2;
        reach_x = PW'(i_geo.hw) + PW'(i_geo.rr);
        reach_y = PW'(i_geo.hh) + PW'(i_geo.rr);
        far     = (dx > reach_x) || (dy > reach_y);
        near    = (dx <= PW'(i_geo.hw)) || (dy <= PW'(i_geo.hh));
        // only meaningful in the corner case, where they stay within the radius
        off_x   = dx - PW'(i_geo.hw);
        off_y   = dy - PW'(i_geo.hh);

        n_dist.valid = i_geo.valid;
        n_dist.ex    = off_x[RW-1:0];
        n_dist.ey    = off_y[RW-1:0];
        n_dist.rr    = i_geo.rr;
        priority if (!i_geo.live || far) begin
            n_dist.cls = CLS_MISS;
        end else if (near) begin
            n_dist.cls = CLS_HIT;
        end else begin
            n_dist.cls = CLS_CORNER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist.valid <= 1'b0;
        end else begin
            r_dist.valid <= n_dist.valid;
        end
        r_dist.cls <= n_dist.cls;
        r_dist.ex  <= n_dist.ex;
        r_dist.ey  <= n_dist.ey;
        r_dist.rr  <= n_dist.rr;
    end

    assign o_dist = r_dist;

endmodule

@@ rtl/cbo_corner.sv @@
// squared corner distance against squared radius, then the result register
module cbo_corner (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cbo_pkg::t_dist i_dist,
    output logic           o_valid,
    output logic           o_hit
);
    import cbo_pkg::*;

    logic            r_sq_valid;
    t_cls            r_sq_cls;
    logic [QW-1:0]   r_ex2;
    logic [QW-1:0]   r_ey2;
    logic [QW-1:0]   r_rr2;
    logic [QW:0]     sum;
    logic            n_hit;
    logic            r_valid;
    logic            r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
        end else begin
            r_sq_valid <= i_dist.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_cls <= i_dist.cls;
        r_ex2    <= QW'(i_dist.ex) * QW'(i_dist.ex);
        r_ey2    <= QW'(i_dist.ey) * QW'(i_dist.ey);
        r_rr2    <= QW'(i_dist.rr) * QW'(i_dist.rr);
    end

    always_comb begin
        sum = (QW+1)'(r_ex2) + (QW+1)'(r_ey2);
        unique case (r_sq_cls)
            CLS_MISS:   n_hit = 1'b0;
            CLS_HIT:    n_hit = 1'b1;
            CLS_CORNER: n_hit = (sum <= (QW+1)'(r_rr2));
            default:    n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= r_sq_valid;
            r_hit   <= r_sq_valid & n_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

@@ rtl/circle_box_overlap_test.sv @@
// Circle versus box overlap test. An item is taken on any cycle with start high;
// busy stays low, so one item per clock is sustained. Each item gives exactly one
// result, o_hit marked by o_valid for a single cycle, after it passes through the
// input register, the extent stage, the distance stage, the square stage and the
// result register. The receiver cannot stall, so results must be caught in the
// cycle they appear. Test mode selects the full box or the inset body; any other
// mode never hits.
module circle_box_overlap_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_box_x,
    input  logic [15:0] i_box_y,
    input  logic [11:0] i_box_width,
    input  logic [11:0] i_box_height,
    input  logic [11:0] i_inset_left,
    input  logic [11:0] i_inset_right,
    input  logic [11:0] i_inset_top,
    input  logic [11:0] i_inset_bottom,
    input  logic [1:0]  i_test_mode,
    input  logic [15:0] i_circle_x,
    input  logic [15:0] i_circle_y,
    input  logic [15:0] i_circle_radius,
    output logic        o_valid,
    output logic        o_hit
);
    import cbo_pkg::*;

    logic                 r_valid;
    logic [CW-1:0]        r_box_x;
    logic [CW-1:0]        r_box_y;
    logic [SIZE_BITS-1:0] r_box_width;
    logic [SIZE_BITS-1:0] r_box_height;
    logic [SIZE_BITS-1:0] r_inset_left;
    logic [SIZE_BITS-1:0] r_inset_right;
    logic [SIZE_BITS-1:0] r_inset_top;
    logic [SIZE_BITS-1:0] r_inset_bottom;
    logic [1:0]           r_test_mode;
    logic [CW-1:0]        r_circle_x;
    logic [CW-1:0]        r_circle_y;
    logic [CW-1:0]        r_circle_radius;
    t_geo                 geo;
    t_dist                distance;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_box_x         <= i_box_x[CW-1:0];
        r_box_y         <= i_box_y[CW-1:0];
        r_box_width     <= i_box_width;
        r_box_height    <= i_box_height;
        r_inset_left    <= i_inset_left;
        r_inset_right   <= i_inset_right;
        r_inset_top     <= i_inset_top;
        r_inset_bottom  <= i_inset_bottom;
        r_test_mode     <= i_test_mode;
        r_circle_x      <= i_circle_x[CW-1:0];
        r_circle_y      <= i_circle_y[CW-1:0];
        r_circle_radius <= i_circle_radius[CW-1:0];
    end

    cbo_geometry u_geometry (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_valid),
        .i_box_x         (r_box_x),
        .i_box_y         (r_box_y),
        .i_box_width     (r_box_width),
        .i_box_height    (r_box_height),
        .i_inset_left    (r_inset_left),
        .i_inset_right   (r_inset_right),
        .i_inset_top     (r_inset_top),
        .i_inset_bottom  (r_inset_bottom),
        .i_test_mode     (r_test_mode),
        .i_circle_x      (r_circle_x),
        .i_circle_y      (r_circle_y),
        .i_circle_radius (r_circle_radius),
        .o_geo           (geo)
    );

    cbo_distance u_distance (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geo   (geo),
        .o_dist  (distance)
    );

    cbo_corner u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dist  (distance),
        .o_valid (o_valid),
        .o_hit   (o_hit)
    );

endmodule

@@ rtl/cbo_checker.sv @@
// port-level checks for the overlap test, bound to the top level
module cbo_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_test_mode,
    input logic       o_valid,
    input logic       o_hit
);
    import cbo_pkg::*;

    // every result traces back to an item taken earlier
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 5))
    else $error("result without a matching item");

    // an item taken with reset held off for its whole flight always returns
    a_item_returns: assert property (@(posedge i_clk)
        ($past(start && !busy, 5) && $past(i_rst_n, 5) && $past(i_rst_n, 4)
         && $past(i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1) && i_rst_n)
        |-> o_valid)
    else $error("item lost");

    // not-solid and unused modes never hit
    a_mode_kill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_test_mode, 5) == MODE_NOT_SOLID
                     || $past(i_test_mode, 5) == MODE_UNUSED))
        |-> !o_hit)
    else $error("hit reported for a body that is not solid");

    // hit only shows alongside its strobe
    a_hit_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_valid)
    else $error("hit without strobe");

    // no result in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
    else $error("result straight out of reset");

endmodule

bind circle_box_overlap_test cbo_checker u_cbo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_test_mode (i_test_mode),
    .o_valid     (o_valid),
    .o_hit       (o_hit)
);

@@ tb/tb_top.sv @@
// self-checking testbench for the circle versus box overlap test, with its own hit predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbo_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESULT_LATENCY = 5;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [15:0] box_x;
        logic [15:0] box_y;
        logic [11:0] box_width;
        logic [11:0] box_height;
        logic [11:0] inset_left;
        logic [11:0] inset_right;
        logic [11:0] inset_top;
        logic [11:0] inset_bottom;
        logic [1:0]  test_mode;
        logic [15:0] circle_x;
        logic [15:0] circle_y;
        logic [15:0] circle_radius;
    } t_overlap_query;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    logic           o_valid;
    logic           o_hit;
    t_overlap_query req;

    logic expected_hits[$];
    int   error_count   = 0;
    int   queries_taken = 0;
    int   hits_seen     = 0;
    int   misses_seen   = 0;
    int   stall_cycles  = 0;
    int   send_gap_pct  = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    circle_box_overlap_test dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_box_x         (req.box_x),
        .i_box_y         (req.box_y),
        .i_box_width     (req.box_width),
        .i_box_height    (req.box_height),
        .i_inset_left    (req.inset_left),
        .i_inset_right   (req.inset_right),
        .i_inset_top     (req.inset_top),
        .i_inset_bottom  (req.inset_bottom),
        .i_test_mode     (req.test_mode),
        .i_circle_x      (req.circle_x),
        .i_circle_y      (req.circle_y),
        .i_circle_radius (req.circle_radius),
        .o_valid         (o_valid),
        .o_hit           (o_hit)
    );

    // solid body length, saturating at zero when the margins eat the box
    function automatic longint body_len(longint full, longint m1, longint m2);
        longint s;
        s = full - m1 - m2;
        return (s < 0) ? 0 : s;
    endfunction

    // exact overlap in half-pixel units
    function automatic logic calc_overlap(t_overlap_query q);
        longint cmask, bx, by, cx, cy, rr, hw, hh, mx, my, dx, dy, ex, ey;
        cmask = (longint'(1) << cbo_pkg::COORD_BITS) - 1;
        bx = longint'(q.box_x) & cmask;
        by = longint'(q.box_y) & cmask;
        cx = longint'(q.circle_x) & cmask;
        cy = longint'(q.circle_y) & cmask;
        rr = 2 * (longint'(q.circle_radius) & cmask);
        if (q.test_mode == MODE_FULL) begin
            hw = q.box_width;
            hh = q.box_height;
            mx = 2 * bx + hw;
            my = 2 * by + hh;
        end else if (q.test_mode == MODE_INSET) begin
            hw = body_len(q.box_width, q.inset_left, q.inset_right);
            hh = body_len(q.box_height, q.inset_top, q.inset_bottom);
            mx = 2 * (bx + q.inset_left) + hw;
            my = 2 * (by + q.inset_top) + hh;
        end else begin
            return 1'b0;
        end
        dx = (2 * cx > mx) ? 2 * cx - mx : mx - 2 * cx;
        dy = (2 * cy > my) ? 2 * cy - my : my - 2 * cy;
        if (dx > hw + rr || dy > hh + rr)
            return 1'b0;
        if (dx <= hw || dy <= hh)
            return 1'b1;
        ex = dx - hw;
        ey = dy - hh;
        return (ex * ex + ey * ey <= rr * rr);
    endfunction

    function automatic t_overlap_query make_query(int bx, int by, int bw, int bh,
                                                  int il, int ir, int it, int ib,
                                                  logic [1:0] mode, int cx, int cy,
                                                  int rad);
        t_overlap_query q;
        q.box_x         = 16'(bx);
        q.box_y         = 16'(by);
        q.box_width     = 12'(bw);
        q.box_height    = 12'(bh);
        q.inset_left    = 12'(il);
        q.inset_right   = 12'(ir);
        q.inset_top     = 12'(it);
        q.inset_bottom  = 12'(ib);
        q.test_mode     = mode;
        q.circle_x      = 16'(cx);
        q.circle_y      = 16'(cy);
        q.circle_radius = 16'(rad);
        return q;
    endfunction

    function automatic logic [15:0] pick_radius();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return 16'($urandom_range(0, 64));
        else if (roll < 9)
            return 16'($urandom_range(0, 4095));
        return 16'($urandom);
    endfunction

    // place the circle centre around the chosen box so hits and misses both show up
    function automatic t_overlap_query aim_circle(t_overlap_query q);
        longint ox, oy, sx, sy, reach_x, reach_y;
        ox = q.box_x;
        oy = q.box_y;
        sx = q.box_width;
        sy = q.box_height;
        if (q.test_mode == MODE_INSET) begin
            ox += q.inset_left;
            oy += q.inset_top;
            sx = body_len(q.box_width, q.inset_left, q.inset_right);
            sy = body_len(q.box_height, q.inset_top, q.inset_bottom);
        end
        reach_x = sx / 2 + q.circle_radius + 4;
        reach_y = sy / 2 + q.circle_radius + 4;
        q.circle_x = 16'(ox + sx / 2 + longint'($urandom_range(0, 2 * reach_x)) - reach_x);
        q.circle_y = 16'(oy + sy / 2 + longint'($urandom_range(0, 2 * reach_y)) - reach_y);
        return q;
    endfunction

    function automatic longint isqrt(longint v);
        longint s;
        s = 0;
        while ((s + 1) * (s + 1) <= v)
            s++;
        return s;
    endfunction

    // present one item, hold it until taken, then idle cycle by cycle at the gap rate
    task automatic issue_query(t_overlap_query q);
        req   <= q;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // drop start and hold off until every expected result is back
    task automatic finish_burst();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_hits.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        // point box and point circle at the origin
        issue_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, MODE_FULL, 0, 0, 0));
        // every field at its top
        issue_query(make_query(65535, 65535, 4095, 4095, 4095, 4095, 4095, 4095,
                               MODE_FULL, 65535, 65535, 65535));
        issue_query(make_query(0, 0, 4095, 4095, 0, 0, 0, 0, MODE_FULL, 65535, 65535, 0));
        issue_query(make_query(65535, 65535, 0, 0, 0, 0, 0, 0, MODE_FULL, 0, 0, 65535));
        issue_query(make_query(0, 0, 4095, 4095, 0, 0, 0, 0, MODE_FULL, 2000, 4095, 0));
        // zero radius on the edge and one pixel past it
        issue_query(make_query(100, 100, 10, 10, 0, 0, 0, 0, MODE_FULL, 110, 105, 0));
        issue_query(make_query(100, 100, 10, 10, 0, 0, 0, 0, MODE_FULL, 111, 105, 0));
        // corner touch at distance exactly the radius, then one short
        issue_query(make_query(100, 100, 10, 10, 0, 0, 0, 0, MODE_FULL, 113, 114, 5));
        issue_query(make_query(100, 100, 10, 10, 0, 0, 0, 0, MODE_FULL, 113, 114, 4));
        // inside both bands but outside the rounded corner
        issue_query(make_query(100, 100, 10, 10, 0, 0, 0, 0, MODE_FULL, 114, 114, 5));
        issue_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, MODE_FULL, 3, 4, 5));
        issue_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, MODE_FULL, 3, 4, 4));
        // inset body edges
        issue_query(make_query(100, 100, 20, 20, 5, 5, 3, 7, MODE_INSET, 116, 108, 1));
        issue_query(make_query(100, 100, 20, 20, 5, 5, 3, 7, MODE_INSET, 117, 108, 1));
        issue_query(make_query(100, 100, 20, 20, 5, 5, 3, 7, MODE_INSET, 103, 108, 1));
        issue_query(make_query(100, 100, 20, 20, 0, 0, 0, 0, MODE_INSET, 120, 120, 0));
        // margins wider than the box collapse the body to a line
        issue_query(make_query(100, 100, 10, 10, 8, 8, 0, 0, MODE_INSET, 108, 120, 10));
        issue_query(make_query(100, 100, 10, 10, 8, 8, 0, 0, MODE_INSET, 109, 105, 0));
        issue_query(make_query(100, 100, 10, 10, 8, 8, 0, 0, MODE_INSET, 108, 105, 0));
        // body pushed past the coordinate range by the margins
        issue_query(make_query(65535, 65535, 0, 0, 4095, 4095, 4095, 4095, MODE_INSET,
                               65535, 65535, 4095));
        issue_query(make_query(65535, 65535, 4095, 4095, 4095, 0, 4095, 0, MODE_INSET,
                               65535, 65535, 65535));
        // not solid and the unused mode never hit, even dead centre
        issue_query(make_query(100, 100, 10, 10, 0, 0, 0, 0, MODE_NOT_SOLID, 105, 105, 50));
        issue_query(make_query(100, 100, 10, 10, 0, 0, 0, 0, MODE_UNUSED, 105, 105, 50));
        issue_query(make_query(0, 0, 4095, 4095, 0, 0, 0, 0, MODE_UNUSED, 0, 0, 65535));
        finish_burst();
    endtask

    task automatic test_full_box(int count);
        t_overlap_query q;
        repeat (count) begin
            q.box_x        = 16'($urandom);
            q.box_y        = 16'($urandom);
            q.box_width    = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 64))
                                                        : 12'($urandom);
            q.box_height   = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 64))
                                                        : 12'($urandom);
            q.inset_left   = 12'($urandom);
            q.inset_right  = 12'($urandom);
            q.inset_top    = 12'($urandom);
            q.inset_bottom = 12'($urandom);
            q.test_mode    = MODE_FULL;
            q.circle_radius = pick_radius();
            issue_query(aim_circle(q));
        end
        finish_burst();
    endtask

    task automatic test_inset_body(int count);
        t_overlap_query q;
        bit             wide_margins;
        repeat (count) begin
            wide_margins   = ($urandom_range(0, 9) < 3);
            q.box_x        = 16'($urandom);
            q.box_y        = 16'($urandom);
            q.box_width    = ($urandom_range(0, 4) != 0) ? 12'($urandom_range(0, 64))
                                                         : 12'($urandom);
            q.box_height   = ($urandom_range(0, 4) != 0) ? 12'($urandom_range(0, 64))
                                                         : 12'($urandom);
            q.inset_left   = wide_margins ? 12'($urandom) : 12'($urandom_range(0, 32));
            q.inset_right  = wide_margins ? 12'($urandom) : 12'($urandom_range(0, 32));
            q.inset_top    = wide_margins ? 12'($urandom) : 12'($urandom_range(0, 32));
            q.inset_bottom = wide_margins ? 12'($urandom) : 12'($urandom_range(0, 32));
            q.test_mode    = MODE_INSET;
            q.circle_radius = pick_radius();
            issue_query(aim_circle(q));
        end
        finish_burst();
    endtask

    // circle centres right on the rounded corner boundary, one pixel either side
    task automatic test_corner_touch(int count);
        t_overlap_query q;
        longint         rad, left, right, top, bottom, ex, ey, tmp;
        repeat (count) begin
            rad            = $urandom_range(1, 60);
            q.box_x        = 16'($urandom_range(200, 60000));
            q.box_y        = 16'($urandom_range(200, 60000));
            q.box_width    = 12'($urandom_range(0, 40));
            q.box_height   = 12'($urandom_range(0, 40));
            q.inset_left   = 12'($urandom_range(0, 15));
            q.inset_right  = 12'($urandom_range(0, 15));
            q.inset_top    = 12'($urandom_range(0, 15));
            q.inset_bottom = 12'($urandom_range(0, 15));
            q.test_mode    = $urandom_range(0, 1) ? MODE_INSET : MODE_FULL;
            q.circle_radius = 16'(rad);
            left   = q.box_x;
            top    = q.box_y;
            right  = left + q.box_width;
            bottom = top + q.box_height;
            if (q.test_mode == MODE_INSET) begin
                left   = q.box_x + q.inset_left;
                top    = q.box_y + q.inset_top;
                right  = left + body_len(q.box_width, q.inset_left, q.inset_right);
                bottom = top + body_len(q.box_height, q.inset_top, q.inset_bottom);
            end
            ex = $urandom_range(0, rad);
            ey = isqrt(rad * rad - ex * ex) + $urandom_range(0, 2) - 1;
            if (ey < 0)
                ey = 0;
            if ($urandom_range(0, 1)) begin
                tmp = ex;
                ex  = ey;
                ey  = tmp;
            end
            q.circle_x = 16'($urandom_range(0, 1) ? right + ex : left - ex);
            q.circle_y = 16'($urandom_range(0, 1) ? bottom + ey : top - ey);
            issue_query(q);
        end
        finish_burst();
    endtask

    // every mode with aimed circles, half of it fully random noise
    task automatic test_mixed_noise(int count);
        t_overlap_query q;
        repeat (count) begin
            q = t_overlap_query'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom});
            if ($urandom_range(0, 1)) begin
                q.circle_radius = pick_radius();
                q = aim_circle(q);
            end
            issue_query(q);
        end
        finish_burst();
    endtask

    // predict on acceptance, check on the result strobe, watch for progress
    always @(posedge i_clk) begin
        logic want;
        logic taken;
        taken = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_hits = {expected_hits, calc_overlap(req)};
                queries_taken++;
                taken = 1'b1;
            end
            if (o_valid) begin
                taken = 1'b1;
                if (expected_hits.size() == 0) begin
                    $error("result with no item outstanding: hit=%b", o_hit);
                    error_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (o_hit !== want) begin
                        $error("hit mismatch: expected %b, got %b", want, o_hit);
                        error_count++;
                    end
                    if (o_hit === 1'b1)
                        hits_seen++;
                    else
                        misses_seen++;
                end
            end
        end
        stall_cycles <= taken ? 0 : stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_hits.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int gap_plan[3];
        gap_plan = '{0, 60, 37};
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        req     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        for (int p = 0; p < 3; p++) begin
            send_gap_pct = gap_plan[p];
            test_full_box(130);
            test_inset_body(160);
            test_corner_touch(170);
            test_mixed_noise(160);
        end

        start <= 1'b0;
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
        if (expected_hits.size() != 0) begin
            $error("%0d results never arrived", expected_hits.size());
            error_count++;
        end
        $display("covered %0d items (%0d hits, %0d misses): full box, inset body,",
                 queries_taken, hits_seen, misses_seen);
        $display("corner boundaries and non-solid modes, sender gaps of 0, 60 and 37 pct");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
